// ----- design/fp32_fp16_converter_top_defines.svh -----
// Assertion macros for the binary32/binary16 converter checker.
`ifndef FP32_FP16_CONVERTER_TOP_DEFINES_SVH
`define FP32_FP16_CONVERTER_TOP_DEFINES_SVH

// same-cycle implication
`define FPC_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fpc check failed");

// delayed implication: the result is checked after the accepted transaction
`define FPC_ASSERT_LAT3(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##3 (cons)) \
		else $error("fpc latency check failed");

`endif

// ----- design/fpc_pkg.sv -----
// Shared types for the binary32/binary16 converter pipeline.
package fpc_pkg;

	typedef enum logic [2:0] {
		OP_N_FIXED,
		OP_N_SUB,
		OP_N_NORM,
		OP_W_PASS,
		OP_W_SUB
	} op_t;

	typedef struct packed {
		op_t         op;
		logic        sign;
		logic [7:0]  e8;
		logic [22:0] man;
		logic [4:0]  shamt;
	} s1_t;

	typedef struct packed {
		logic       kind;
		logic       sign;
		logic [7:0] e8;
		logic [9:0] man10;
		logic       inc;
	} s2_t;

endpackage

// ----- design/fpc_decode.sv -----
// Stage 1: operand classification, exponent rebias, shift amounts.
module fpc_decode (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             valid_in,
	input  logic             kind,
	input  logic [31:0]      operand,
	output logic             valid_s1,
	output fpc_pkg::s1_t     data_s1
);

	fpc_pkg::s1_t d;
	logic [7:0]  nexp;
	logic [9:0]  pay;
	logic [4:0]  hexp;
	logic [9:0]  hman;
	logic [3:0]  lz;

	always_comb begin
		nexp = operand[30:23];
		pay  = (operand[22:13] == 10'd0) ? 10'd1 : operand[22:13];
		hexp = operand[14:10];
		hman = operand[9:0];
		lz   = 4'd0;
		for (int i = 0; i < 10; i++) begin
			if (hman[i]) lz = 4'(10 - i);
		end
		d.shamt = 5'd0;
		d.man   = operand[22:0];
		d.e8    = 8'd0;
		if (!kind) begin
			d.sign = operand[31];
			if (nexp == 8'hFF) begin
				d.op = fpc_pkg::OP_N_FIXED;
				d.e8 = 8'd31;
				d.man = (operand[22:0] == 23'd0) ? 23'd0 : {pay, 13'd0};
			end else if (nexp >= 8'd143) begin
				d.op = fpc_pkg::OP_N_FIXED;
				d.e8 = 8'd31;
				d.man = 23'd0;
			end else if (nexp >= 8'd113) begin
				d.op = fpc_pkg::OP_N_NORM;
				d.e8 = nexp - 8'd112;
			end else if (nexp >= 8'd102) begin
				d.op = fpc_pkg::OP_N_SUB;
				d.shamt = 5'(8'd126 - nexp);
			end else begin
				d.op = fpc_pkg::OP_N_FIXED;
				d.man = 23'd0;
			end
		end else begin
			d.sign = operand[15];
			d.man  = {hman, 13'd0};
			if (hexp == 5'd0) begin
				if (hman == 10'd0) begin
					d.op = fpc_pkg::OP_W_PASS;
				end else begin
					d.op = fpc_pkg::OP_W_SUB;
					d.e8 = 8'd113 - {4'd0, lz};
					d.shamt = {1'b0, lz};
				end
			end else if (hexp == 5'd31) begin
				d.op = fpc_pkg::OP_W_PASS;
				d.e8 = 8'hFF;
			end else begin
				d.op = fpc_pkg::OP_W_PASS;
				d.e8 = {3'd0, hexp} + 8'd112;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_in) begin
			data_s1 <= d;
		end
	end

endmodule

// ----- design/fpc_align.sv -----
// Stage 2: mantissa shifts and round-increment decision.
module fpc_align (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             valid_s1,
	input  fpc_pkg::s1_t     data_s1,
	output logic             valid_s2,
	output fpc_pkg::s2_t     data_s2
);

	fpc_pkg::s2_t d;
	logic [23:0] full;
	logic [23:0] sh;
	logic [23:0] shr;
	logic [9:0]  wm;

	always_comb begin
		full = {1'b1, data_s1.man};
		sh   = full >> data_s1.shamt;
		shr  = full >> (data_s1.shamt - 5'd1);
		wm   = data_s1.man[22:13] << data_s1.shamt[3:0];
		d.sign  = data_s1.sign;
		d.e8    = data_s1.e8;
		d.man10 = data_s1.man[22:13];
		d.inc   = 1'b0;
		d.kind  = 1'b0;
		unique case (data_s1.op)
			fpc_pkg::OP_N_FIXED: begin
			end
			fpc_pkg::OP_N_NORM: begin
				d.inc = data_s1.man[12] && ((|data_s1.man[11:0]) || data_s1.man[13]);
			end
			fpc_pkg::OP_N_SUB: begin
				d.e8    = 8'd0;
				d.man10 = sh[9:0];
				d.inc   = shr[0];
			end
			fpc_pkg::OP_W_PASS: begin
				d.kind = 1'b1;
			end
			fpc_pkg::OP_W_SUB: begin
				d.kind  = 1'b1;
				d.man10 = wm;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			data_s2 <= d;
		end
	end

endmodule

// ----- design/fpc_pack.sv -----
// Stage 3: rounding add and result packing into the output register.
module fpc_pack (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             valid_s2,
	input  fpc_pkg::s2_t     data_s2,
	output logic             valid_s3,
	output logic [31:0]      result_s3
);

	logic [14:0] half;
	logic [31:0] res;

	always_comb begin
		half = {data_s2.e8[4:0], data_s2.man10} + {14'd0, data_s2.inc};
		if (data_s2.kind) begin
			res = {data_s2.sign, data_s2.e8, data_s2.man10, 13'd0};
		end else begin
			res = {16'd0, data_s2.sign, half};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			result_s3 <= res;
		end
	end

endmodule

// ----- design/fp32_fp16_converter_top.sv -----
// Top level of the binary32/binary16 bit-pattern converter.
// Usage:
//   A transaction is accepted on a rising edge with start high and busy low.
//   kind 0 narrows a binary32 operand to binary16 (low 16 bits of converted,
//   upper bits zero); kind 1 widens operand[15:0] to binary32.
//   busy is always low: the three-stage pipeline takes one transaction every
//   cycle, so throughput is one conversion per clock.
//   done and converted are driven by the pack register stage, after the decode
//   and align register stages; done is high for a single cycle per result,
//   and the receiver samples the result while done is high.
//   The receiver cannot stall; each result is taken in its done cycle.
//   Reset (arst_n low, asynchronous) clears all stage valid bits, dropping
//   any transactions in flight; no result appears until new ones enter.
module fp32_fp16_converter_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        kind,
	input  logic [31:0] operand,
	output logic        done,
	output logic [31:0] converted
);

	logic          valid_s1;
	logic          valid_s2;
	fpc_pkg::s1_t  data_s1;
	fpc_pkg::s2_t  data_s2;

	assign busy = 1'b0;

	fpc_decode u_decode (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_in (start & ~busy),
		.kind     (kind),
		.operand  (operand),
		.valid_s1 (valid_s1),
		.data_s1  (data_s1)
	);

	fpc_align u_align (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.data_s1  (data_s1),
		.valid_s2 (valid_s2),
		.data_s2  (data_s2)
	);

	fpc_pack u_pack (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s2  (valid_s2),
		.data_s2   (data_s2),
		.valid_s3  (done),
		.result_s3 (converted)
	);

endmodule

// ----- design/fpc_checker.sv -----
// Port-level checker for the converter, bound to the top level.
`include "fp32_fp16_converter_top_defines.svh"

module fpc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        kind,
	input logic [31:0] operand,
	input logic        done,
	input logic [31:0] converted
);

	`FPC_ASSERT_IMPL(a_never_busy, 1'b1, !busy)
	`FPC_ASSERT_LAT3(a_result_follows, start && !busy, done)
	`FPC_ASSERT_IMPL(a_no_spurious, done, $past(start && !busy, 3))
	`FPC_ASSERT_IMPL(a_narrow_upper_zero, done && !$past(kind, 3), converted[31:16] == 16'h0)

endmodule

bind fp32_fp16_converter_top fpc_checker u_fpc_checker (.*);

// ----- verif/tb.sv -----
// Self-checking testbench for the binary32/binary16 converter: directed table, then random conversions.
`timescale 1ns / 1ps

module tb;

	localparam logic KIND_NARROW = 1'b0;
	localparam logic KIND_WIDEN  = 1'b1;

	localparam logic [14:0] HALF_INF     = 15'h7C00;
	localparam int          SETTLE       = 8;
	localparam int          STALL_LIMIT  = 200;
	localparam int          PHASE_ITEMS  = 317;
	localparam int          REPORT_LIMIT = 10;

	localparam logic [12:0] ROUND_TAILS [5] = '{13'h1000, 13'h0FFF, 13'h1001, 13'h0000, 13'h1FFF};

	typedef struct packed {
		logic        kind_sel;
		logic [31:0] operand_bits;
		logic        has_value;
		logic [31:0] value;
	} stim_row_t;

	typedef struct packed {
		logic        kind_sel;
		logic [31:0] operand_bits;
		logic [31:0] value;
	} pending_t;

	stim_row_t directed_rows [26] = '{
		'{KIND_NARROW, 32'h0000_0000, 1'b1, 32'h0000_0000},
		'{KIND_NARROW, 32'h8000_0000, 1'b1, 32'h0000_8000},
		'{KIND_NARROW, 32'h7F80_0000, 1'b1, 32'h0000_7C00},
		'{KIND_NARROW, 32'hFF80_0000, 1'b1, 32'h0000_FC00},
		'{KIND_NARROW, 32'h7F80_0001, 1'b1, 32'h0000_7C01},
		'{KIND_NARROW, 32'hFFFF_FFFF, 1'b1, 32'h0000_FFFF},
		'{KIND_NARROW, 32'h7F7F_FFFF, 1'b1, 32'h0000_7C00},
		'{KIND_NARROW, 32'h3F80_0000, 1'b1, 32'h0000_3C00},
		'{KIND_NARROW, 32'h0000_0001, 1'b0, 32'h0},
		'{KIND_NARROW, 32'h807F_FFFF, 1'b0, 32'h0},
		'{KIND_NARROW, 32'h3300_0000, 1'b0, 32'h0},
		'{KIND_NARROW, 32'hB2FF_FFFF, 1'b0, 32'h0},
		'{KIND_NARROW, 32'h387F_E000, 1'b0, 32'h0},
		'{KIND_NARROW, 32'h3F80_1000, 1'b0, 32'h0},
		'{KIND_NARROW, 32'h3F80_3000, 1'b0, 32'h0},
		'{KIND_NARROW, 32'h477F_E000, 1'b0, 32'h0},
		'{KIND_NARROW, 32'h477F_F000, 1'b0, 32'h0},
		'{KIND_WIDEN,  32'h0000_0000, 1'b1, 32'h0000_0000},
		'{KIND_WIDEN,  32'h0000_8000, 1'b1, 32'h8000_0000},
		'{KIND_WIDEN,  32'h0000_7C00, 1'b1, 32'h7F80_0000},
		'{KIND_WIDEN,  32'hFFFF_FFFF, 1'b1, 32'hFFFF_E000},
		'{KIND_WIDEN,  32'hABCD_3C00, 1'b1, 32'h3F80_0000},
		'{KIND_WIDEN,  32'h0000_0001, 1'b0, 32'h0},
		'{KIND_WIDEN,  32'h0000_83FF, 1'b0, 32'h0},
		'{KIND_WIDEN,  32'h0000_7BFF, 1'b0, 32'h0},
		'{KIND_WIDEN,  32'h0000_7C01, 1'b0, 32'h0}
	};

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        kind;
	logic [31:0] operand;
	logic        done;
	logic [31:0] converted;

	logic        row_typed;
	logic [31:0] row_value;

	pending_t pending_results [$];
	int       error_count;
	int       narrow_count;
	int       widen_count;
	int       stall_cycles;
	int       idle_pct [3] = '{0, 58, 13};

	fp32_fp16_converter_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.kind      (kind),
		.operand   (operand),
		.done      (done),
		.converted (converted)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic [31:0] converted_value(input logic k, input logic [31:0] op);
		logic        s;
		logic [7:0]  e8;
		logic [22:0] m23;
		logic [4:0]  e5;
		logic [31:0] m;
		logic [31:0] full;
		int          hexp;
		int          shift;
		int          lz;
		if (k == KIND_NARROW) begin
			s   = op[31];
			e8  = op[30:23];
			m23 = op[22:0];
			if (e8 == 8'hFF) begin
				if (m23 == '0)
					return {16'd0, s, HALF_INF};
				m = {22'd0, m23[22:13]};
				if (m == '0)
					m = 32'd1;
				return {16'd0, s, 5'h1F, m[9:0]};
			end
			hexp = int'(e8) - 112;
			if (hexp >= 31)
				return {16'd0, s, HALF_INF};
			if (hexp <= 0) begin
				if (hexp < -10)
					return {16'd0, s, 15'd0};
				full  = {8'd0, 1'b1, m23};
				shift = 14 - hexp;
				m     = full >> shift;
				if (full[shift - 1])
					m++;
				return {16'd0, s, m[14:0]};
			end
			// round to nearest even on the dropped 13 bits
			m = {22'd0, m23[22:13]};
			if (m23[12:0] > 13'h1000 || (m23[12:0] == 13'h1000 && m[0])) begin
				m++;
				if (m == 32'h400) begin
					m = '0;
					hexp++;
					if (hexp >= 31)
						return {16'd0, s, HALF_INF};
				end
			end
			return {16'd0, s, hexp[4:0], m[9:0]};
		end
		s  = op[15];
		e5 = op[14:10];
		m  = {22'd0, op[9:0]};
		if (e5 == '0) begin
			if (m == '0)
				return {s, 31'd0};
			lz = 0;
			while (!m[10] && lz < 11) begin
				m = m << 1;
				lz++;
			end
			return {s, 8'(113 - lz), m[9:0], 13'd0};
		end
		if (e5 == 5'h1F)
			return {s, 8'hFF, m[9:0], 13'd0};
		return {s, 8'(int'(e5) + 112), m[9:0], 13'd0};
	endfunction

	task automatic issue_conversion(input logic k, input logic [31:0] op, input logic has_val,
			input logic [31:0] val);
		start     <= 1'b1;
		kind      <= k;
		operand   <= op;
		row_typed <= has_val;
		row_value <= val;
		do @(posedge clk); while (busy !== 1'b0);
	endtask

	// scoreboard: retire results, then log newly accepted transactions
	always @(posedge clk) begin
		if (arst_n) begin
			if (done === 1'b1) begin
				if (pending_results.size() == 0) begin
					if (error_count < REPORT_LIMIT)
						$display("unexpected result %08h with nothing pending", converted);
					error_count++;
				end else begin
					pending_t exp_item;
					exp_item = pending_results.pop_front();
					if (converted !== exp_item.value) begin
						if (error_count < REPORT_LIMIT)
							$display("mismatch kind=%0b operand=%08h expected %08h got %08h",
								exp_item.kind_sel, exp_item.operand_bits, exp_item.value, converted);
						error_count++;
					end
				end
			end
			if (start && busy === 1'b0) begin
				pending_t log_item;
				log_item = '{kind, operand,
					row_typed ? row_value : converted_value(kind, operand)};
				pending_results.insert(pending_results.size(), log_item);
				if (kind == KIND_NARROW)
					narrow_count++;
				else
					widen_count++;
			end
		end
	end

	always @(posedge clk) begin
		if ((start && busy === 1'b0) || done === 1'b1)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("watchdog: no progress for %0d cycles", STALL_LIMIT);
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		logic        s;
		logic        k;
		logic [22:0] m;
		logic [31:0] op;
		error_count  = 0;
		narrow_count = 0;
		widen_count  = 0;
		stall_cycles = 0;
		arst_n    <= 1'b0;
		start     <= 1'b0;
		kind      <= KIND_NARROW;
		operand   <= '0;
		row_typed <= 1'b0;
		row_value <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[r])
			issue_conversion(directed_rows[r].kind_sel, directed_rows[r].operand_bits,
				directed_rows[r].has_value, directed_rows[r].value);

		for (int p = 0; p < 3; p++) begin
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (idle_pct[p] != 0 && (i % 50) >= 10 && $urandom_range(0, 99) < idle_pct[p]) begin
					start <= 1'b0;
					repeat ($urandom_range(1, 4)) @(posedge clk);
				end
				s = 1'($urandom);
				m = 23'($urandom);
				k = 1'($urandom);
				if (k == KIND_NARROW) begin
					case ($urandom_range(0, 7))
						0, 1: op = $urandom;
						2: op = {s, 8'($urandom_range(102, 142)), m};
						3: op = {s, 8'($urandom_range(103, 142)), m[22:13],
							ROUND_TAILS[$urandom_range(0, 4)]};
						4: op = {s, 8'($urandom_range(98, 113)), m};
						5: op = {s, 8'hFF, ($urandom_range(0, 1) ? m : {10'd0, m[12:0]})};
						6: op = {s, 8'($urandom_range(141, 143)), 10'h3FF, m[12:0]};
						default: op = {s, 8'($urandom_range(0, 2)), m};
					endcase
				end else begin
					case ($urandom_range(0, 3))
						0: op = $urandom;
						1: op = {16'($urandom), s, 5'd0, m[9:0]};
						2: op = {16'($urandom), s, 5'h1F,
							($urandom_range(0, 3) == 0 ? 10'd0 : m[9:0])};
						default: op = {16'($urandom), s, 5'($urandom_range(1, 30)), m[9:0]};
					endcase
				end
				issue_conversion(k, op, 1'b0, 32'h0);
			end
		end
		start <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (pending_results.size() != 0) begin
			$display("%0d results never arrived", pending_results.size());
			error_count++;
		end

		$display("Ran %0d narrowing and %0d widening conversions", narrow_count, widen_count);
		$display("Sender idle settings: none, 58 and 13 percent; %0d errors", error_count);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
